// File: src/cooperative_task_scheduler_macros.svh
// Assertion macros used by the scheduler checker.
`ifndef COOPERATIVE_TASK_SCHEDULER_MACROS_SVH
`define COOPERATIVE_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cts_pkg.sv
`default_nettype none

package cts_pkg;

  // Table size and result limit.
  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 3;
  localparam int TIME_W   = 32;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;
  localparam int RUNS_W   = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD,
    OP_DELETE,
    OP_TICK,
    OP_DISPATCH
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE,
    ST_FULL,
    ST_BAD_SLOT,
    ST_RUN,
    ST_NONE
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  // Contents of one task slot.
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic [RUNS_W-1:0] runs;
  } entry_t;

  // Result of processing the slot at the head of the ring.
  typedef struct packed {
    logic              hit;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } unit_res_t;

endpackage

`default_nettype wire

// File: src/cts_if.sv
`default_nettype none

// Request channel: one operation per transaction.
interface cts_req_if;
  logic                          valid;
  logic                          ready;
  logic [cts_pkg::OP_W-1:0]      op;
  logic [cts_pkg::SLOT_W-1:0]    slot;
  logic [cts_pkg::TIME_W-1:0]    start_delay;
  logic [cts_pkg::TIME_W-1:0]    repeat_period;
  logic [cts_pkg::TAG_W-1:0]     task_tag;

  modport source (output valid, op, slot, start_delay, repeat_period, task_tag,
                  input ready);
  modport sink (input valid, op, slot, start_delay, repeat_period, task_tag,
                output ready);
endinterface

// Response channel: one result per transaction.
interface cts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cts_pkg::STATUS_W-1:0]  status;
  logic [cts_pkg::SLOT_W-1:0]    out_slot;
  logic [cts_pkg::TAG_W-1:0]     run_tag;
  logic                          last;

  modport source (output valid, status, out_slot, run_tag, last, input ready);
  modport sink (input valid, status, out_slot, run_tag, last, output ready);
endinterface

`default_nettype wire

// File: src/cts_cell.sv
`default_nettype none

// One slot of the ring: holds its entry and takes its neighbor's on a shift.
module cts_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire cts_pkg::entry_t d,
  output cts_pkg::entry_t      q
);

  cts_pkg::entry_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift) begin
      entry <= d;
    end
  end

  assign q = entry;

endmodule

`default_nettype wire

// File: src/cts_unit.sv
`default_nettype none

// Applies the current operation to the entry leaving the head of the ring.
module cts_unit (
  input  wire cts_pkg::op_t                op,
  input  wire logic [cts_pkg::TAG_W-1:0]   new_tag,
  input  wire logic [cts_pkg::TIME_W-1:0]  new_delay,
  input  wire logic [cts_pkg::TIME_W-1:0]  new_period,
  input  wire logic [cts_pkg::SLOT_W-1:0]  slot_lo,
  input  wire logic                        del_match,
  input  wire logic                        armed,
  input  wire cts_pkg::entry_t             e,
  output cts_pkg::entry_t                  e_next,
  output cts_pkg::unit_res_t               res
);

  always_comb begin
    e_next = e;
    res    = '{hit: 1'b0, status: cts_pkg::ST_DONE, slot: '0, tag: '0};
    case (op)
      cts_pkg::OP_ADD: begin
        // First free slot takes the new task.
        if (armed && !e.valid) begin
          e_next = '{valid: 1'b1, tag: new_tag, delay: new_delay,
                     period: new_period, runs: '0};
          res    = '{hit: 1'b1, status: cts_pkg::ST_DONE, slot: slot_lo, tag: '0};
        end
      end
      cts_pkg::OP_DELETE: begin
        if (del_match && e.valid) begin
          e_next = '0;
          res    = '{hit: 1'b1, status: cts_pkg::ST_DONE, slot: '0, tag: '0};
        end
      end
      cts_pkg::OP_TICK: begin
        // Count down, or log a run and, when the period is nonzero, reload the delay from it.
        if (e.valid) begin
          if (e.delay != '0) begin
            e_next.delay = e.delay - 1'b1;
          end else begin
            if (e.runs != '1) begin
              e_next.runs = e.runs + 1'b1;
            end
            if (e.period != '0) begin
              e_next.delay = e.period;
            end
          end
        end
      end
      cts_pkg::OP_DISPATCH: begin
        // Consume one pending run; one-shot tasks are freed afterward.
        if (armed && e.valid && e.runs != '0) begin
          res = '{hit: 1'b1, status: cts_pkg::ST_RUN, slot: slot_lo, tag: e.tag};
          if (e.period == '0) begin
            e_next = '0;
          end else begin
            e_next.runs = e.runs - 1'b1;
          end
        end
      end
      default: begin
        e_next = e;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/cooperative_task_scheduler.sv
// Cooperative task scheduler with a table of NUM_SLOTS task slots.
// The req channel takes one operation per transaction: add a task, delete a
// slot, advance time by one tick, or dispatch every task with a pending run.
// The rsp channel returns results; last marks the final result of a request.
// Add, delete and tick give one result; dispatch gives one result per task
// that runs, in slot order (at most eight), or a single none-ready result.
// The slots sit in a ring of cells that shifts one slot per cycle during a walk,
// unless a stall halts it, past a single update unit. A request is accepted in
// the idle state, walks every slot past the unit and then, from the finish
// state, loads its final result into the output register; only then does the
// block return to idle and take the next request.
// req.ready is high only while no request is being walked.
// Results pass through an output register; if the receiver stalls while a
// dispatch has a further result to post, the ring halts until it drains.
// Synchronous reset clears every slot and drops any pending result.
`default_nettype none

module cooperative_task_scheduler #(
  parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  cts_req_if.sink  req,
  cts_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  cts_pkg::state_t state, state_next;
  logic [CNT_W-1:0] step;

  // Latched request.
  cts_pkg::op_t                  op_q;
  logic [cts_pkg::SLOT_W-1:0]    slot_q;
  logic [cts_pkg::TIME_W-1:0]    delay_q;
  logic [cts_pkg::TIME_W-1:0]    period_q;
  logic [cts_pkg::TAG_W-1:0]     tag_q;

  // Result held back until it is known whether it is the last one.
  cts_pkg::status_t              hold_status;
  logic [cts_pkg::SLOT_W-1:0]    hold_slot;
  logic [cts_pkg::TAG_W-1:0]     hold_tag;
  logic [cts_pkg::RES_CNT_W-1:0] nres;

  // Output register.
  logic                          o_valid;
  logic [cts_pkg::STATUS_W-1:0]  o_status;
  logic [cts_pkg::SLOT_W-1:0]    o_slot;
  logic [cts_pkg::TAG_W-1:0]     o_tag;
  logic                          o_last;

  cts_pkg::entry_t    cell_q [NUM_SLOTS];
  cts_pkg::entry_t    head_next;
  cts_pkg::unit_res_t ures;

  logic accept, advance, push_hold, final_load, out_free, last_step;
  logic armed, del_match;
  logic [cts_pkg::SLOT_W-1:0] slot_lo;

  assign accept    = req.valid && req.ready;
  assign out_free  = !o_valid || rsp.ready;
  assign last_step = (step == CNT_W'(NUM_SLOTS - 1));
  assign slot_lo   = cts_pkg::SLOT_W'(step);
  assign del_match = ({{(32 - cts_pkg::SLOT_W){1'b0}}, slot_q} == 32'(step));

  // Add stops after the first placement; dispatch stops at the result limit.
  always_comb begin
    case (op_q)
      cts_pkg::OP_ADD:      armed = (hold_status == cts_pkg::ST_FULL);
      cts_pkg::OP_DISPATCH: armed = (nres < cts_pkg::RES_CNT_W'(cts_pkg::MAX_RESULTS));
      default:              armed = 1'b1;
    endcase
  end

  // Ring of slot cells; the head entry goes through the unit to the tail.
  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    cts_pkg::entry_t d_in;
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign d_in = head_next;
    end else begin : g_mid
      assign d_in = cell_q[k + 1];
    end
    cts_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (advance),
      .d     (d_in),
      .q     (cell_q[k])
    );
  end

  cts_unit u_unit (
    .op         (op_q),
    .new_tag    (tag_q),
    .new_delay  (delay_q),
    .new_period (period_q),
    .slot_lo    (slot_lo),
    .del_match  (del_match),
    .armed      (armed),
    .e          (cell_q[0]),
    .e_next     (head_next),
    .res        (ures)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cts_pkg::S_IDLE:   if (accept) state_next = cts_pkg::S_WALK;
      cts_pkg::S_WALK:   if (advance && last_step) state_next = cts_pkg::S_FINISH;
      cts_pkg::S_FINISH: if (out_free) state_next = cts_pkg::S_IDLE;
      default:           state_next = cts_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req.ready  = 1'b0;
    push_hold  = 1'b0;
    advance    = 1'b0;
    final_load = 1'b0;
    case (state)
      cts_pkg::S_IDLE: begin
        req.ready = 1'b1;
      end
      cts_pkg::S_WALK: begin
        push_hold = ures.hit && (op_q == cts_pkg::OP_DISPATCH) &&
                    (hold_status == cts_pkg::ST_RUN);
        advance   = !push_hold || out_free;
      end
      cts_pkg::S_FINISH: begin
        final_load = out_free;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  // State, step counter and result count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cts_pkg::S_IDLE;
      step  <= '0;
      nres  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
        nres <= '0;
      end else if (advance) begin
        step <= CNT_W'(step + 1'b1);
        if (ures.hit && op_q == cts_pkg::OP_DISPATCH) begin
          nres <= cts_pkg::RES_CNT_W'(nres + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= cts_pkg::op_t'(req.op);
      slot_q    <= req.slot;
      delay_q   <= req.start_delay;
      period_q  <= req.repeat_period;
      tag_q     <= req.task_tag;
      hold_slot <= '0;
      hold_tag  <= '0;
      case (cts_pkg::op_t'(req.op))
        cts_pkg::OP_ADD:    hold_status <= cts_pkg::ST_FULL;
        cts_pkg::OP_DELETE: hold_status <= cts_pkg::ST_BAD_SLOT;
        cts_pkg::OP_TICK:   hold_status <= cts_pkg::ST_DONE;
        default:            hold_status <= cts_pkg::ST_NONE;
      endcase
    end else if (advance && ures.hit) begin
      hold_status <= ures.status;
      hold_slot   <= ures.slot;
      hold_tag    <= ures.tag;
    end
  end

  // Output register: earlier dispatch results leave with last low.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if ((push_hold && advance) || final_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((push_hold && advance) || final_load) begin
      o_status <= hold_status;
      o_slot   <= hold_slot;
      o_tag    <= hold_tag;
      o_last   <= final_load;
    end
  end

  assign rsp.valid    = o_valid;
  assign rsp.status   = o_status;
  assign rsp.out_slot = o_slot;
  assign rsp.run_tag  = o_tag;
  assign rsp.last     = o_last;

endmodule

`default_nettype wire

// File: src/cts_checker.sv
`default_nettype none
`include "cooperative_task_scheduler_macros.svh"

// Port-level checks on the scheduler.
module cts_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic [cts_pkg::STATUS_W-1:0] status,
  input wire logic [cts_pkg::SLOT_W-1:0]   out_slot,
  input wire logic [cts_pkg::TAG_W-1:0]    run_tag,
  input wire logic                         last
);

  logic run_result, single_result;

  assign run_result    = rsp_valid && (status == cts_pkg::ST_RUN);
  assign single_result = rsp_valid && ((status == cts_pkg::ST_FULL) ||
                         (status == cts_pkg::ST_BAD_SLOT) || (status == cts_pkg::ST_NONE));

  // A stalled result keeps its payload.
  `CTS_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(out_slot) && $stable(run_tag) && $stable(last), "result changed while stalled")

  // The block takes one request at a time.
  `CTS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request accepted while busy")

  // Failure and none-ready results always end their request.
  `CTS_ASSERT_NOW(a_single_last, single_result, last, "lone result without last")

  // Only a task run carries a tag.
  `CTS_ASSERT_NOW(a_tag_zero, rsp_valid && !run_result, run_tag == '0, "tag on a non-run result")

endmodule

bind cooperative_task_scheduler cts_checker u_cts_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .out_slot  (rsp.out_slot),
  .run_tag   (rsp.run_tag),
  .last      (rsp.last)
);

`default_nettype wire
